FILE: hw/rtl/tpe_pkg.sv
// ----------------------------------------------------------------------------
// tpe_pkg
// Shared types and constants of the trivariate polynomial evaluate unit.
// ----------------------------------------------------------------------------
package tpe_pkg;

   // Coefficient store geometry; power fields are 2 bits wide on the bus
   localparam int MAX_EXTENT  = 4;
   localparam int POW_W       = 2;
   localparam int STORE_DEPTH = MAX_EXTENT * MAX_EXTENT * MAX_EXTENT;
   localparam int ADDR_W      = 3 * POW_W;
   localparam int EXT_W       = 3;
   localparam int COEF_W      = 32;
   localparam int WIDE_W      = 64;

   localparam logic [EXT_W-1:0] EXT_RESET = 3'd4;

   // Transaction kinds (req_tuser)
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // Register indexes
   localparam logic [1:0] CSR_EXTENT_X = 2'd0;
   localparam logic [1:0] CSR_EXTENT_Y = 2'd1;
   localparam logic [1:0] CSR_EXTENT_Z = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_TERM_X,
      ST_TERM_Y,
      ST_TERM_Z,
      ST_ACC,
      ST_POW_X,
      ST_POW_Y,
      ST_POW_Z,
      ST_CLIP
   } tpe_state_type;

   typedef struct packed {
      logic              start;
      logic [WIDE_W-1:0] a;
      logic [WIDE_W-1:0] b;
   } tpe_mul_req_type;

   typedef struct packed {
      logic              done;
      logic              sat;
      logic [WIDE_W-1:0] res;
   } tpe_mul_rsp_type;

endpackage

FILE: hw/rtl/trivariate_polynomial_evaluate_unit.sv
// ----------------------------------------------------------------------------
// trivariate_polynomial_evaluate_unit
// Coefficient store and evaluator for a polynomial in x, y and z, Q16.16.
// ----------------------------------------------------------------------------
// A write transaction (tuser = 0) stores coefficient c(l,m,n) and returns
// nothing. An evaluate transaction (tuser = 1) returns
// sum c(l,m,n) * x^l * y^m * z^n over l < extent_x, m < extent_y,
// n < extent_z, summed with l outermost and n innermost; each term is
// ((c * x^l) * y^m) * z^n. Every product is exact, shifted right
// arithmetically by FRAC_BITS and saturated to 64 bits; the running sum is
// 64-bit saturating; the result is clipped to 32 bits and rsp_tuser flags any
// saturation on the way. The coefficients live in a 64 x 32 RAM with
// registered read; per-entry valid bits, cleared by reset, make unwritten
// entries read as zero. All products go through one shared multiplier that
// forms one 32x32 partial product per cycle. An evaluation works term by
// term: a RAM read, three products and an accumulate per term, a power
// update product between terms, and a final clip step, which stretches while
// the output register still holds an unaccepted result. The unit is back in
// idle in the cycle after the clip step; a write transaction is accepted in
// idle. One transaction is worked on at a time; a finished result sits in
// the output register, so the next transaction can be accepted while it
// waits. Extent registers read 0 as 1 and values above 4 as 4; they may
// only be written while the unit is idle.
// ----------------------------------------------------------------------------
module trivariate_polynomial_evaluate_unit
   import tpe_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // power_x[1:0], power_y[3:2], power_z[5:4], coef_value[37:6],
   // arg_x[69:38], arg_y[101:70], arg_z[133:102], zero [135:134]
   input  logic [135:0] req_tdata,
   // op[0]
   input  logic [0:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // value[31:0]
   output logic [31:0]  rsp_tdata,
   // saturated[0]
   output logic [0:0]   rsp_tuser,
   // register write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [2:0]   csr_wdata
);

   localparam logic [WIDE_W-1:0] ONE_Q   = 64'd1 << FRAC_BITS;
   localparam logic [31:0]       OUT_MAX = 32'h7fff_ffff;
   localparam logic [31:0]       OUT_MIN = 32'h8000_0000;
   localparam logic [WIDE_W-1:0] SUM_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
   localparam logic [WIDE_W-1:0] SUM_MIN = {1'b1, {(WIDE_W-1){1'b0}}};

   // request fields
   logic [POW_W-1:0]  f_power_x, f_power_y, f_power_z;
   logic [COEF_W-1:0] f_coef, f_arg_x, f_arg_y, f_arg_z;

   assign f_power_x = req_tdata[1:0];
   assign f_power_y = req_tdata[3:2];
   assign f_power_z = req_tdata[5:4];
   assign f_coef    = req_tdata[37:6];
   assign f_arg_x   = req_tdata[69:38];
   assign f_arg_y   = req_tdata[101:70];
   assign f_arg_z   = req_tdata[133:102];

   // control
   tpe_state_type     state_ff, state_in;
   logic              mul_issued_ff, mul_issued_in;
   logic [STORE_DEPTH-1:0] valid_ff, valid_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [EXT_W-1:0]  ext_x_ff, ext_x_in;
   logic [EXT_W-1:0]  ext_y_ff, ext_y_in;
   logic [EXT_W-1:0]  ext_z_ff, ext_z_in;

   // datapath
   logic [POW_W-1:0]  l_ff, l_in, m_ff, m_in, n_ff, n_in;
   logic [POW_W-1:0]  ex_last_ff, ex_last_in;
   logic [POW_W-1:0]  ey_last_ff, ey_last_in;
   logic [POW_W-1:0]  ez_last_ff, ez_last_in;
   logic [COEF_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [WIDE_W-1:0] xl_ff, xl_in, ym_ff, ym_in, zn_ff, zn_in;
   logic [WIDE_W-1:0] t_ff, t_in, r_ff, r_in;
   logic              sat_ff, sat_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_sat_ff, rsp_sat_in;

   // internal
   logic              req_accept;
   logic              is_write, is_eval;
   logic              ram_ren;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [COEF_W-1:0] ram_rdata;
   logic [WIDE_W-1:0] coef_wide;
   tpe_mul_req_type   mul_req;
   tpe_mul_rsp_type   mul_rsp;
   logic              n_end, m_end, l_end;
   logic [WIDE_W-1:0] sum_raw;
   logic              sum_pos_ovf, sum_neg_ovf;
   logic              fits32;
   logic              out_free;

   function automatic logic [POW_W-1:0] clamp_last(input logic [EXT_W-1:0] e);
      logic [POW_W-1:0] res;
      if (e == '0) begin
         res = '0;
      end else if (e > EXT_W'(MAX_EXTENT)) begin
         res = POW_W'(MAX_EXTENT - 1);
      end else begin
         res = POW_W'(e - EXT_W'(1));
      end
      return res;
   endfunction

   assign req_accept = req_tvalid & req_tready;
   assign is_write   = req_accept & (req_tuser[0] == OP_WRITE);
   assign is_eval    = req_accept & (req_tuser[0] == OP_EVAL);

   // 2-bit power fields always index inside the store: (l*4 + m)*4 + n
   assign wr_addr   = {f_power_x, f_power_y, f_power_z};
   assign rd_addr   = {l_ff, m_ff, n_ff};
   assign coef_wide = rd_valid_ff ? {{32{ram_rdata[31]}}, ram_rdata} : '0;

   assign n_end = (n_ff == ez_last_ff);
   assign m_end = (m_ff == ey_last_ff);
   assign l_end = (l_ff == ex_last_ff);

   // saturating accumulate
   assign sum_raw     = r_ff + t_ff;
   assign sum_pos_ovf = ~r_ff[63] & ~t_ff[63] & sum_raw[63];
   assign sum_neg_ovf = r_ff[63] & t_ff[63] & ~sum_raw[63];

   assign fits32   = (&r_ff[63:31]) | ~(|r_ff[63:31]);
   assign out_free = ~rsp_valid_ff | rsp_tready;

   assign csr_ready = 1'b1;

   // -------------------------------------------------------------------------
   // next state
   // -------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (is_eval) state_in = ST_READ;
         end
         ST_READ:   state_in = ST_TERM_X;
         ST_TERM_X: begin
            if (mul_rsp.done) state_in = ST_TERM_Y;
         end
         ST_TERM_Y: begin
            if (mul_rsp.done) state_in = ST_TERM_Z;
         end
         ST_TERM_Z: begin
            if (mul_rsp.done) state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!n_end) begin
               state_in = ST_POW_Z;
            end else if (!m_end) begin
               state_in = ST_POW_Y;
            end else if (!l_end) begin
               state_in = ST_POW_X;
            end else begin
               state_in = ST_CLIP;
            end
         end
         ST_POW_X, ST_POW_Y, ST_POW_Z: begin
            if (mul_rsp.done) state_in = ST_READ;
         end
         ST_CLIP: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // -------------------------------------------------------------------------
   // state outputs: handshake, RAM read, multiplier operands
   // -------------------------------------------------------------------------
   always_comb begin
      req_tready    = 1'b0;
      ram_ren       = 1'b0;
      mul_req.start = 1'b0;
      mul_req.a     = '0;
      mul_req.b     = '0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_READ: ram_ren    = 1'b1;
         ST_TERM_X: begin
            mul_req.start = ~mul_issued_ff;
            mul_req.a     = coef_wide;
            mul_req.b     = xl_ff;
         end
         ST_TERM_Y: begin
            mul_req.start = ~mul_issued_ff;
            mul_req.a     = t_ff;
            mul_req.b     = ym_ff;
         end
         ST_TERM_Z: begin
            mul_req.start = ~mul_issued_ff;
            mul_req.a     = t_ff;
            mul_req.b     = zn_ff;
         end
         ST_POW_X: begin
            mul_req.start = ~mul_issued_ff;
            mul_req.a     = xl_ff;
            mul_req.b     = {{32{x_ff[31]}}, x_ff};
         end
         ST_POW_Y: begin
            mul_req.start = ~mul_issued_ff;
            mul_req.a     = ym_ff;
            mul_req.b     = {{32{y_ff[31]}}, y_ff};
         end
         ST_POW_Z: begin
            mul_req.start = ~mul_issued_ff;
            mul_req.a     = zn_ff;
            mul_req.b     = {{32{z_ff[31]}}, z_ff};
         end
         default: ;
      endcase
   end

   // -------------------------------------------------------------------------
   // register next values
   // -------------------------------------------------------------------------
   always_comb begin
      mul_issued_in = mul_issued_ff;
      if (mul_req.start) begin
         mul_issued_in = 1'b1;
      end else if (mul_rsp.done) begin
         mul_issued_in = 1'b0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (is_write) valid_in[wr_addr] = 1'b1;
   end

   assign rd_valid_in = ram_ren ? valid_ff[rd_addr] : rd_valid_ff;

   always_comb begin
      ext_x_in = ext_x_ff;
      ext_y_in = ext_y_ff;
      ext_z_in = ext_z_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXTENT_X: ext_x_in = csr_wdata;
            CSR_EXTENT_Y: ext_y_in = csr_wdata;
            CSR_EXTENT_Z: ext_z_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      l_in        = l_ff;
      m_in        = m_ff;
      n_in        = n_ff;
      ex_last_in  = ex_last_ff;
      ey_last_in  = ey_last_ff;
      ez_last_in  = ez_last_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      xl_in       = xl_ff;
      ym_in       = ym_ff;
      zn_in       = zn_ff;
      t_in        = t_ff;
      r_in        = r_ff;
      sat_in      = sat_ff;
      rsp_data_in = rsp_data_ff;
      rsp_sat_in  = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (is_eval) begin
               x_in       = f_arg_x;
               y_in       = f_arg_y;
               z_in       = f_arg_z;
               ex_last_in = clamp_last(ext_x_ff);
               ey_last_in = clamp_last(ext_y_ff);
               ez_last_in = clamp_last(ext_z_ff);
               l_in       = '0;
               m_in       = '0;
               n_in       = '0;
               xl_in      = ONE_Q;
               ym_in      = ONE_Q;
               zn_in      = ONE_Q;
               r_in       = '0;
               sat_in     = 1'b0;
            end
         end
         ST_TERM_X, ST_TERM_Y, ST_TERM_Z: begin
            if (mul_rsp.done) begin
               t_in   = mul_rsp.res;
               sat_in = sat_ff | mul_rsp.sat;
            end
         end
         ST_POW_X: begin
            if (mul_rsp.done) begin
               xl_in  = mul_rsp.res;
               sat_in = sat_ff | mul_rsp.sat;
            end
         end
         ST_POW_Y: begin
            if (mul_rsp.done) begin
               ym_in  = mul_rsp.res;
               sat_in = sat_ff | mul_rsp.sat;
            end
         end
         ST_POW_Z: begin
            if (mul_rsp.done) begin
               zn_in  = mul_rsp.res;
               sat_in = sat_ff | mul_rsp.sat;
            end
         end
         ST_ACC: begin
            if (sum_pos_ovf) begin
               r_in = SUM_MAX;
            end else if (sum_neg_ovf) begin
               r_in = SUM_MIN;
            end else begin
               r_in = sum_raw;
            end
            sat_in = sat_ff | sum_pos_ovf | sum_neg_ovf;
            // walk n, then m, then l; inner powers restart at one
            if (!n_end) begin
               n_in = n_ff + POW_W'(1);
            end else if (!m_end) begin
               m_in  = m_ff + POW_W'(1);
               n_in  = '0;
               zn_in = ONE_Q;
            end else if (!l_end) begin
               l_in  = l_ff + POW_W'(1);
               m_in  = '0;
               n_in  = '0;
               ym_in = ONE_Q;
               zn_in = ONE_Q;
            end
         end
         ST_CLIP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fits32 ? r_ff[31:0] : (r_ff[63] ? OUT_MIN : OUT_MAX);
               rsp_sat_in   = sat_ff | ~fits32;
            end
         end
         default: ;
      endcase
   end

   // -------------------------------------------------------------------------
   // registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mul_issued_ff <= 1'b0;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ext_x_ff      <= EXT_RESET;
         ext_y_ff      <= EXT_RESET;
         ext_z_ff      <= EXT_RESET;
      end else begin
         state_ff      <= state_in;
         mul_issued_ff <= mul_issued_in;
         valid_ff      <= valid_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         ext_x_ff      <= ext_x_in;
         ext_y_ff      <= ext_y_in;
         ext_z_ff      <= ext_z_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff        <= l_in;
      m_ff        <= m_in;
      n_ff        <= n_in;
      ex_last_ff  <= ex_last_in;
      ey_last_ff  <= ey_last_in;
      ez_last_ff  <= ez_last_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      xl_ff       <= xl_in;
      ym_ff       <= ym_in;
      zn_ff       <= zn_in;
      t_ff        <= t_in;
      r_ff        <= r_in;
      sat_ff      <= sat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

   // -------------------------------------------------------------------------
   // coefficient store and shared multiplier
   // -------------------------------------------------------------------------
   // writes happen only in idle, reads only during an evaluation, so the
   // two ports never touch the same entry in the same cycle
   tpe_ram #(
      .WIDTH (COEF_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (is_write),
      .wr_addr (wr_addr),
      .wr_data (f_coef),
      .rd_en   (ram_ren),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   tpe_qmul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_qmul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

`ifndef NO_ASSERTIONS
   a_loop_in_extent: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |->
         (l_ff <= ex_last_ff && m_ff <= ey_last_ff && n_ff <= ez_last_ff))
      else $error("loop index beyond extent");

   a_done_was_issued: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> mul_issued_ff)
      else $error("multiplier result without a request");

   a_result_from_clip: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_CLIP))
      else $error("result loaded outside the clip step");
`endif

endmodule

FILE: hw/rtl/tpe_ram.sv
// ----------------------------------------------------------------------------
// tpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/tpe_qmul.sv
// ----------------------------------------------------------------------------
// tpe_qmul
// Multi-cycle signed 64x64 fixed-point multiply: four 32x32 partial
// products, sign fix, arithmetic shift by FRAC_BITS, saturation to 64 bits.
// ----------------------------------------------------------------------------
module tpe_qmul
   import tpe_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  tpe_mul_req_type mul_req,
   output tpe_mul_rsp_type mul_rsp
);

   localparam logic [2:0]        STEP_ACC_LAST = 3'd4;
   localparam logic [2:0]        STEP_NEG      = 3'd5;
   localparam logic [2:0]        STEP_LAST     = 3'd6;
   localparam logic [WIDE_W-1:0] WIDE_MAX      = {1'b0, {(WIDE_W-1){1'b1}}};
   localparam logic [WIDE_W-1:0] WIDE_MIN      = {1'b1, {(WIDE_W-1){1'b0}}};

   logic                     busy_ff, busy_in;
   logic [2:0]               step_ff, step_in;
   logic                     neg_ff, neg_in;
   logic [WIDE_W-1:0]        ua_ff, ua_in;
   logic [WIDE_W-1:0]        ub_ff, ub_in;
   logic [WIDE_W-1:0]        prod_ff, prod_in;
   logic [2*WIDE_W-1:0]      acc_ff, acc_in;
   logic                     done_ff, done_in;
   logic                     sat_ff, sat_in;
   logic [WIDE_W-1:0]        res_ff, res_in;

   logic [31:0]              a_half;
   logic [31:0]              b_half;
   logic [WIDE_W-1:0]        prod_mul;
   logic [2*WIDE_W-1:0]      addend;
   logic signed [2*WIDE_W-1:0] shifted;
   logic                     fits;

   // step 0: a0*b0, 1: a0*b1, 2: a1*b0, 3: a1*b1
   assign a_half   = step_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
   assign b_half   = step_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
   assign prod_mul = a_half * b_half;

   // previous partial product lands at its weight
   always_comb begin
      case (step_ff) inside
         3'd1:       addend = {64'b0, prod_ff};
         3'd2, 3'd3: addend = {32'b0, prod_ff, 32'b0};
         3'd4:       addend = {prod_ff, 64'b0};
         default:    addend = '0;
      endcase
   end

   assign shifted = $signed(acc_ff) >>> FRAC_BITS;
   assign fits    = (&shifted[127:63]) | ~(|shifted[127:63]);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      res_in  = res_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = mul_req.a[63] ^ mul_req.b[63];
         ua_in   = mul_req.a[63] ? (~mul_req.a + 64'd1) : mul_req.a;
         ub_in   = mul_req.b[63] ? (~mul_req.b + 64'd1) : mul_req.b;
         acc_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff < STEP_ACC_LAST) begin
            prod_in = prod_mul;
         end
         if (step_ff <= STEP_ACC_LAST) begin
            acc_in = acc_ff + addend;
         end
         if (step_ff == STEP_NEG && neg_ff) begin
            acc_in = ~acc_ff + 128'd1;
         end
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            sat_in  = ~fits;
            res_in  = fits ? shifted[63:0] : (shifted[127] ? WIDE_MIN : WIDE_MAX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      sat_ff  <= sat_in;
      res_ff  <= res_in;
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.sat  = sat_ff;
   assign mul_rsp.res  = res_ff;

`ifndef NO_ASSERTIONS
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !busy_ff)
      else $error("multiply started while busy");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff) && $past(step_ff == STEP_LAST))
      else $error("done without a finished run");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff <= STEP_LAST)
      else $error("step counter overran");
`endif

endmodule
